// ===== sv/sha1bs_pkg.sv =====
// Shared types and constants for the SHA-1 byte-stream hasher.
// Used by sha1bs_round and sha1_byte_stream_hasher_core; no dependencies.
package sha1bs_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_WORDS = BLOCK_BYTES / 4;
  localparam int unsigned NUM_ROUNDS  = 80;
  localparam int unsigned HASH_WORDS  = 5;

  // Byte offset where the length field starts in the final block
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'(BLOCK_BYTES - 1);
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] WORD_LAST  = 3'(HASH_WORDS - 1);

  // Input modes
  localparam logic [1:0] MODE_ABSORB = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;

  // Round constants
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  typedef logic [HASH_WORDS-1:0][31:0]  hash_t;
  typedef logic [BLOCK_WORDS-1:0][31:0] block_t;

  localparam hash_t HASH_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // Compression unit sequencer
  typedef enum logic [1:0] {
    RND_IDLE,
    RND_RUN,
    RND_DONE
  } rnd_state_e;

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK_START,
    ST_BLK_WAIT,
    ST_PAD1_START,
    ST_PAD1_WAIT,
    ST_PAD2_START,
    ST_PAD2_WAIT,
    ST_EMIT
  } core_state_e;

endpackage

// ===== sv/sha1_byte_stream_hasher_core.sv =====
// SHA-1 byte-stream hasher, top level. Absorb beats are taken while idle; after
// the beat that completes a 64-byte block, in_ready stays low while the round
// unit runs. Finish or peek: the pad block is compressed (and a second block
// when 56 or more bytes sit in the block), then five digest beats follow. Rate
// is set by the single round unit.
// Reset restores the SHA-1 initial hash, zero fill and zero length.
// Depends on sha1bs_pkg and sha1bs_round.
module sha1_byte_stream_hasher_core import sha1bs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  core_state_e state_q, state_d;
  logic [5:0]  fill_q;
  logic [36:0] total_q;
  hash_t       chain_q;
  hash_t       dig_q;
  block_t      buf_q;
  logic [2:0]  idx_q;
  logic        fin_q;

  logic        in_fire, out_fire;
  logic        start, done;
  logic        two_blk;
  logic        sel_full, sel_pad1, sel_pad2;
  hash_t       base, hash_res;
  block_t      blk;
  logic [39:0] len_bits;
  logic [1:0]  lane;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;
  assign two_blk  = fill_q >= LEN_OFFSET;
  assign len_bits = {total_q, 3'b000};
  assign lane     = ~fill_q[1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    start       = 1'b0;
    base        = chain_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_data_i.mode) inside
            MODE_ABSORB: if (fill_q == FILL_LAST) state_d = ST_BLK_START;
            MODE_FINISH, MODE_PEEK: state_d = ST_PAD1_START;
            default: ;
          endcase
        end
      end
      ST_BLK_START: begin
        start   = 1'b1;
        state_d = ST_BLK_WAIT;
      end
      ST_BLK_WAIT: if (done) state_d = ST_IDLE;
      ST_PAD1_START: begin
        start   = 1'b1;
        state_d = ST_PAD1_WAIT;
      end
      ST_PAD1_WAIT: if (done) state_d = two_blk ? ST_PAD2_START : ST_EMIT;
      ST_PAD2_START: begin
        start   = 1'b1;
        base    = dig_q;
        state_d = ST_PAD2_WAIT;
      end
      ST_PAD2_WAIT: if (done) state_d = ST_EMIT;
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && idx_q == WORD_LAST) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Block image for the round unit: full buffer, first pad block or
  // length-only second block
  assign sel_full = state_q == ST_BLK_START;
  assign sel_pad1 = state_q == ST_PAD1_START;
  assign sel_pad2 = state_q == ST_PAD2_START;

  always_comb begin
    blk = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (sel_full || (sel_pad1 && 6'(i) < fill_q)) begin
        blk[i/4][8*(3-i%4) +: 8] = buf_q[i/4][8*(3-i%4) +: 8];
      end else if (sel_pad1 && 6'(i) == fill_q) begin
        blk[i/4][8*(3-i%4) +: 8] = PAD_BYTE;
      end
    end
    if (sel_pad2 || (sel_pad1 && !two_blk)) begin
      blk[BLOCK_WORDS-2] = {24'd0, len_bits[39:32]};
      blk[BLOCK_WORDS-1] = len_bits[31:0];
    end
  end

  sha1bs_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .base_i  (base),
    .block_i (blk),
    .done_o  (done),
    .hash_o  (hash_res)
  );

  // Control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      chain_q <= HASH_INIT;
      idx_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        idx_q <= '0;
        fin_q <= in_data_i.mode == MODE_FINISH;
        if (in_data_i.mode == MODE_ABSORB) begin
          fill_q  <= fill_q + 6'd1;
          total_q <= total_q + 37'd1;
        end
      end
      if (state_q == ST_BLK_WAIT && done) chain_q <= hash_res;
      if (out_fire) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == WORD_LAST && fin_q) begin
          chain_q <= HASH_INIT;
          fill_q  <= '0;
          total_q <= '0;
        end
      end
    end
  end

  // Message buffer and digest scratch
  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.mode == MODE_ABSORB) begin
      buf_q[fill_q[5:2]][{lane, 3'b000} +: 8] <= in_data_i.data_byte;
    end
    if ((state_q == ST_PAD1_WAIT || state_q == ST_PAD2_WAIT) && done) begin
      dig_q <= hash_res;
    end
  end

  // Digest beats
  always_comb begin
    out_data_o.digest_word = dig_q[idx_q];
    out_data_o.word_index  = idx_q;
    out_data_o.last_word   = idx_q == WORD_LAST;
  end

endmodule

// ===== sv/sha1bs_round.sv =====
// SHA-1 compression unit: one round per cycle through all NUM_ROUNDS rounds, then the
// feed-forward add. Depends on sha1bs_pkg.
module sha1bs_round import sha1bs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  hash_t  base_i,
  input  block_t block_i,
  output logic   done_o,
  output hash_t  hash_o
);

  rnd_state_e  state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  hash_t       h_q;
  block_t      w_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] f, k, t, w_new;

  // Round function and constant select
  always_comb begin
    if (cnt_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K_0;
    end else if (cnt_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K_1;
    end else if (cnt_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K_2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K_3;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_o  = 1'b0;
    unique case (state_q)
      RND_IDLE: begin
        cnt_d = '0;
        if (start_i) state_d = RND_RUN;
      end
      RND_RUN: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(NUM_ROUNDS - 1)) state_d = RND_DONE;
      end
      RND_DONE: begin
        done_o  = 1'b1;
        state_d = RND_IDLE;
      end
      default: state_d = RND_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RND_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working variables and message schedule (16-word sliding window)
  always_ff @(posedge clk_i) begin
    if (state_q == RND_IDLE && start_i) begin
      h_q <= base_i;
      w_q <= block_i;
      a_q <= base_i[0];
      b_q <= base_i[1];
      c_q <= base_i[2];
      d_q <= base_i[3];
      e_q <= base_i[4];
    end else if (state_q == RND_RUN) begin
      w_q <= {{w_new[30:0], w_new[31]}, w_q[BLOCK_WORDS-1:1]};
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // Feed-forward add, valid while done_o is high
  assign hash_o = {h_q[4] + e_q, h_q[3] + d_q, h_q[2] + c_q,
                   h_q[1] + b_q, h_q[0] + a_q};

endmodule

// ===== test/tb_top.sv =====
// Testbench for sha1_byte_stream_hasher_core: random byte streams with finish and peek,
// each digest beat checked against an in-bench SHA-1 model.
// Depends on sha1bs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top import sha1bs_pkg::*; ();

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         ITEM_COUNT  = 310;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         DRAIN_WAIT  = 200;
  // Message lengths around the padding and block boundaries
  localparam int         EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  // Running hash state as the core should hold it
  typedef struct packed {
    hash_t       cv;
    block_t      blk;
    logic [5:0]  fill;
    logic [36:0] total;
  } sha_state_t;

  // Digest model plus queue of digest beats still owed by the core
  class sha1_digest_board;
    sha_state_t run_state;
    out_t       digest_q[$];
    int         errors;

    function new();
      errors    = 0;
      run_state = fresh_state();
      run_state.blk = '0;
    endfunction

    function sha_state_t fresh_state();
      sha_state_t s;
      s       = run_state;
      s.cv    = HASH_INIT;
      s.fill  = '0;
      s.total = '0;
      return s;
    endfunction

    // One 80-round compression, added into the chaining words
    function hash_t mix_block(hash_t cv, block_t blk);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 80; i++) begin
        x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {x[30:0], x[31]};
      end
      a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3]; e = cv[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = K_0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = K_1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_2;
        end else begin
          f = b ^ c ^ d;
          k = K_3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      cv[0] += a; cv[1] += b; cv[2] += c; cv[3] += d; cv[4] += e;
      return cv;
    endfunction

    // Place one byte big-endian in the block; a full block is compressed
    function sha_state_t put_byte(sha_state_t s, logic [7:0] byte_v);
      int sh;
      sh = 8 * (3 - int'(s.fill[1:0]));
      s.blk[s.fill[5:2]][sh +: 8] = byte_v;
      if (s.fill == FILL_LAST) s.cv = mix_block(s.cv, s.blk);
      s.fill = s.fill + 6'd1;
      return s;
    endfunction

    // Standard padding: marker byte, zeros to offset 56, 64-bit bit length
    function sha_state_t pad_out(sha_state_t s);
      logic [63:0] bit_len;
      bit_len = {24'b0, s.total, 3'b0};
      s = put_byte(s, PAD_BYTE);
      while (s.fill != LEN_OFFSET) s = put_byte(s, 8'h00);
      for (int i = 7; i >= 0; i--) s = put_byte(s, bit_len[8*i +: 8]);
      return s;
    endfunction

    function void queue_digest(hash_t cv);
      for (int i = 0; i < HASH_WORDS; i++)
        digest_q.push_back('{digest_word: cv[i], word_index: 3'(i),
                             last_word: (3'(i) == WORD_LAST)});
    endfunction

    function void note_input(in_t beat);
      sha_state_t tmp;
      case (beat.mode)
        MODE_ABSORB: begin
          run_state.total = run_state.total + 37'd1;
          run_state = put_byte(run_state, beat.data_byte);
        end
        MODE_FINISH: begin
          run_state = pad_out(run_state);
          queue_digest(run_state.cv);
          run_state = fresh_state();
        end
        MODE_PEEK: begin
          tmp = pad_out(run_state);
          queue_digest(tmp.cv);
        end
        default: ; // unused mode leaves everything alone
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (digest_q.size() == 0) begin
        report($sformatf("digest beat with nothing pending: %h", got));
        return;
      end
      want = digest_q.pop_front();
      if (got.digest_word !== want.digest_word)
        report($sformatf("digest_word %h, want %h", got.digest_word, want.digest_word));
      if (got.word_index !== want.word_index)
        report($sformatf("word_index %0d, want %0d", got.word_index, want.word_index));
      if (got.last_word !== want.last_word)
        report($sformatf("last_word %b, want %b", got.last_word, want.last_word));
    endtask

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  sha1_digest_board board;
  int               items_sent = 0;
  int               in_calm    = 0;
  int               out_calm   = 0;
  int               out_hold   = 0;
  int               quiet_cycles = 0;

  sha1_byte_stream_hasher_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle cycles before the next beat; occasional runs with no idling at all
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // Present one input beat and hold it until accepted
  task automatic send_beat(logic [1:0] mode, logic [7:0] byte_v);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= '{mode: mode, data_byte: byte_v};
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input('{mode: mode, data_byte: byte_v});
    if (mode != MODE_UNUSED) items_sent++;
    gap = draw_wait(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random message: mostly short, some on padding edges, a few multi-block
  task automatic send_message();
    int len;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = $urandom_range(0, 20);
    else if (pick < 9) len = EDGE_LENS[$urandom_range(0, 7)];
    else len = $urandom_range(21, 130);
    for (int i = 0; i < len; i++) begin
      // stop the stream close to the item budget
      if (items_sent >= ITEM_COUNT) break;
      if ($urandom_range(0, 11) == 0) send_beat(MODE_PEEK, 8'($urandom));
      if ($urandom_range(0, 29) == 0) send_beat(MODE_UNUSED, 8'($urandom));
      send_beat(MODE_ABSORB, 8'($urandom));
    end
    send_beat(MODE_FINISH, 8'($urandom));
  endtask

  // Result side: random back-pressure, every beat checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_result(out_data_o);
        out_hold = draw_wait(out_calm);
        if (out_hold != 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (out_hold > 0) out_hold--;
        if (out_hold == 0) out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, ignored bytes, unused mode, short message
    send_beat(MODE_PEEK,   8'h00);
    send_beat(MODE_FINISH, 8'hFF);
    send_beat(MODE_ABSORB, 8'h00);
    send_beat(MODE_ABSORB, 8'hFF);
    send_beat(MODE_UNUSED, 8'hFF);
    send_beat(MODE_PEEK,   8'hA5);
    send_beat(MODE_ABSORB, 8'h55);
    send_beat(MODE_ABSORB, 8'hAA);
    send_beat(MODE_FINISH, 8'h5A);
    send_beat(MODE_ABSORB, 8'h61);
    send_beat(MODE_ABSORB, 8'h62);
    send_beat(MODE_ABSORB, 8'h63);
    send_beat(MODE_UNUSED, 8'h00);
    send_beat(MODE_PEEK,   8'hFF);
    send_beat(MODE_PEEK,   8'h00);
    send_beat(MODE_FINISH, 8'h00);
    send_beat(MODE_ABSORB, 8'h80);
    send_beat(MODE_FINISH, 8'h7F);

    while (items_sent < ITEM_COUNT) send_message();

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
